### sv/ptmm_pkg.sv
// shared types and constants for the port table mailbox manager
// no dependencies
`timescale 1ns / 1ps

package ptmm_pkg;

    localparam int PORTS         = 64;
    localparam int QUEUE_DEPTH   = 8;
    localparam int MESSAGE_WIDTH = 32;

    localparam int SLOT_W = $clog2(PORTS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W  = $clog2(PORTS + 1);
    localparam int ADDR_W = SLOT_W + PTR_W;
    localparam int STORE_DEPTH = PORTS * QUEUE_DEPTH;

    typedef enum logic [2:0] {
        CMD_ALLOC    = 3'd0,
        CMD_FREE     = 3'd1,
        CMD_ENQ      = 3'd2,
        CMD_DEQ      = 3'd3,
        CMD_SET_SEND = 3'd4,
        CMD_SET_RECV = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_FULL       = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_EMPTY      = 3'd4
    } status_t;

    // one word of the slot ram: right code, ring pointers and fill count
    typedef struct packed {
        logic [2:0]        right;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
    } slot_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch input item, look up slot
        logic execute;   // update slot state and ring memory
        logic emit;      // load output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

### sv/port_table_mailbox_manager_unit.sv
// top level of the port table mailbox manager
// depends on ptmm_pkg, ptmm_ctrl, ptmm_datapath
`timescale 1ns / 1ps

// usage
// one command transfer on the s_ channel gives exactly one result transfer on m_
// s_axis_tdata: command, port_id, right_code, message_in (low bits first)
// m_axis_tdata: status, port_name, message_out, ports_in_use (low bits first)
// a command passes through capture, fetch and execute: capture latches it, looks up
// the slot and reads its slot word; fetch reads the message store at the ring head;
// execute updates the slot word and ring and loads the output register; a new
// command is taken only once the last has executed, set by the read-modify-write
// of the slot and store rams
// the output register lets the next command be latched while a result waits;
// if the receiver stalls, that command holds in execute until the result goes
// reset clears the in-use bits, the in-use count and both channels
// ring pointers are cleared when a slot is allocated
// message store contents are not cleared; a slot only reads what it wrote

module port_table_mailbox_manager_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], port_id[9:3], right_code[12:10], message_in[44:13]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], port_name[9:3], message_out[41:10], ports_in_use[48:42]
    output logic [55:0] m_axis_tdata
);
    import ptmm_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [2:0]  o_status;
    logic [6:0]  o_name;
    logic [31:0] o_msg;
    logic [6:0]  o_count;

    ptmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ptmm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_command       (s_axis_tdata[2:0]),
        .in_port_id       (s_axis_tdata[9:3]),
        .in_right_code    (s_axis_tdata[12:10]),
        .in_message       (s_axis_tdata[44:13]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_status       (o_status),
        .out_port_name    (o_name),
        .out_message      (o_msg),
        .out_ports_in_use (o_count)
    );

    assign m_axis_tdata = {7'd0, o_count, o_msg, o_name, o_status};

endmodule

### sv/ptmm_ram.sv
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps

module ptmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/ptmm_datapath.sv
// slot table, ring pointers, message store and output register
// depends on ptmm_pkg and ptmm_ram
`timescale 1ns / 1ps

module ptmm_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptmm_pkg::dp_cmd_t    cmd,
    output ptmm_pkg::dp_stat_t   stat,
    input  logic [2:0]           in_command,
    input  logic [6:0]           in_port_id,
    input  logic [2:0]           in_right_code,
    input  logic [31:0]          in_message,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [2:0]           out_status,
    output logic [6:0]           out_port_name,
    output logic [31:0]          out_message,
    output logic [6:0]           out_ports_in_use
);
    import ptmm_pkg::*;

    logic [PORTS-1:0]         used_reg;
    logic [CNT_W-1:0]         total_reg;

    logic [2:0]               cmd_reg;
    logic [2:0]               right_code_reg;
    logic [MESSAGE_WIDTH-1:0] msg_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     valid_port_reg;
    logic                     has_free_reg;
    logic [SLOT_W-1:0]        free_slot_reg;

    logic                     ovalid_reg;
    logic [2:0]               ostatus_reg;
    logic [6:0]               oname_reg;
    logic [31:0]              omsg_reg;
    logic [6:0]               ocount_reg;

    logic [SLOT_W-1:0] lookup_slot;
    logic              lookup_ok;
    logic              has_free;
    logic [SLOT_W-1:0] free_slot;

    logic              slot_wr_en;
    logic [SLOT_W-1:0] slot_wr_addr;
    slot_word_t        slot_wr_data;
    logic [SLOT_W-1:0] slot_rd_addr;
    slot_word_t        slot_rd_data;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [MESSAGE_WIDTH-1:0] rd_data;

    logic [2:0]               res_status;
    logic [6:0]               res_name;
    logic                     res_deq;

    // lowest free slot, priority search
    always_comb begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = PORTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                has_free  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        lookup_slot = SLOT_W'(in_port_id - 7'd1);
        lookup_ok   = (in_port_id != 7'd0) && ({25'd0, in_port_id} <= 32'(PORTS))
                      && used_reg[lookup_slot];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg        <= in_command;
            right_code_reg <= in_right_code;
            msg_reg        <= MESSAGE_WIDTH'(in_message);
            slot_reg       <= lookup_slot;
            valid_port_reg <= lookup_ok;
            has_free_reg   <= has_free;
            free_slot_reg  <= free_slot;
        end
    end

    // slot word read at capture, then held on the latched slot
    assign slot_rd_addr = cmd.capture ? lookup_slot : slot_reg;

    ptmm_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (PORTS)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    // message store read at the ring head once the slot word is in
    assign rd_addr = {slot_reg, slot_rd_data.head};
    assign wr_addr = {slot_reg, slot_rd_data.tail};
    assign wr_en   = cmd.execute && cmd_reg == CMD_ENQ && res_status == ST_OK;

    ptmm_ram #(
        .WIDTH (MESSAGE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (msg_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        res_status = ST_OK;
        res_name   = 7'd0;
        res_deq    = 1'b0;
        case (cmd_reg)
            CMD_ALLOC: begin
                if (has_free_reg) begin
                    res_name = 7'(free_slot_reg + 7'd1);
                end else begin
                    res_status = ST_TABLE_FULL;
                end
            end
            CMD_FREE, CMD_SET_SEND, CMD_SET_RECV: begin
                if (!valid_port_reg) res_status = ST_INVALID;
            end
            CMD_ENQ: begin
                if (!valid_port_reg) begin
                    res_status = ST_INVALID;
                end else if (slot_rd_data.fill >= FILL_W'(QUEUE_DEPTH)) begin
                    res_status = ST_FULL;
                end
            end
            CMD_DEQ: begin
                if (!valid_port_reg) begin
                    res_status = ST_INVALID;
                end else if (slot_rd_data.fill == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_deq = 1'b1;
                end
            end
            default: res_status = ST_INVALID;
        endcase
    end

    // slot word update, pointers cleared on allocate and free
    always_comb begin
        slot_wr_en   = 1'b0;
        slot_wr_addr = slot_reg;
        slot_wr_data = slot_rd_data;
        if (cmd.execute && res_status == ST_OK) begin
            case (cmd_reg)
                CMD_ALLOC: begin
                    slot_wr_en         = 1'b1;
                    slot_wr_addr       = free_slot_reg;
                    slot_wr_data.right = right_code_reg;
                    slot_wr_data.head  = '0;
                    slot_wr_data.tail  = '0;
                    slot_wr_data.fill  = '0;
                end
                CMD_FREE: begin
                    slot_wr_en        = 1'b1;
                    slot_wr_data.head = '0;
                    slot_wr_data.tail = '0;
                    slot_wr_data.fill = '0;
                end
                CMD_ENQ: begin
                    slot_wr_en        = 1'b1;
                    slot_wr_data.tail = PTR_W'((32'(slot_rd_data.tail) + 1) % QUEUE_DEPTH);
                    slot_wr_data.fill = slot_rd_data.fill + FILL_W'(1);
                end
                CMD_DEQ: begin
                    slot_wr_en        = 1'b1;
                    slot_wr_data.head = PTR_W'((32'(slot_rd_data.head) + 1) % QUEUE_DEPTH);
                    slot_wr_data.fill = slot_rd_data.fill - FILL_W'(1);
                end
                CMD_SET_SEND: begin
                    slot_wr_en         = 1'b1;
                    slot_wr_data.right = 3'd0;
                end
                CMD_SET_RECV: begin
                    slot_wr_en         = 1'b1;
                    slot_wr_data.right = 3'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            total_reg <= '0;
        end else if (cmd.execute && res_status == ST_OK) begin
            case (cmd_reg)
                CMD_ALLOC: begin
                    used_reg[free_slot_reg] <= 1'b1;
                    total_reg               <= total_reg + CNT_W'(1);
                end
                CMD_FREE: begin
                    used_reg[slot_reg] <= 1'b0;
                    total_reg          <= total_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // output register, holds until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ostatus_reg <= res_status;
            oname_reg   <= res_name;
            omsg_reg    <= res_deq ? 32'(rd_data) : 32'd0;
            case (cmd_reg)
                CMD_ALLOC: ocount_reg <= 7'(total_reg + CNT_W'(has_free_reg));
                CMD_FREE:  ocount_reg <= 7'(total_reg - CNT_W'(valid_port_reg));
                default:   ocount_reg <= 7'(total_reg);
            endcase
        end
    end

    assign stat.out_busy    = ovalid_reg && !out_ready;
    assign out_valid        = ovalid_reg;
    assign out_status       = ostatus_reg;
    assign out_port_name    = oname_reg;
    assign out_message      = omsg_reg;
    assign out_ports_in_use = ocount_reg;

endmodule

### sv/ptmm_ctrl.sv
// command sequencer: capture, fetch, then execute and emit
// depends on ptmm_pkg
`timescale 1ns / 1ps

module ptmm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    output ptmm_pkg::dp_cmd_t  cmd,
    input  ptmm_pkg::dp_stat_t stat
);
    import ptmm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t state_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC) && !stat.out_busy;
    assign cmd.emit    = cmd.execute;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE:  if (in_valid) state_reg <= S_FETCH;
                S_FETCH: state_reg <= S_EXEC;
                S_EXEC:  if (!stat.out_busy) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/ptmm_checker.sv
// port-level checks for the port table mailbox manager
// depends on port_table_mailbox_manager_unit
`timescale 1ns / 1ps

module ptmm_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // one command in flight: no accept the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");

    // a name is only given with success
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[9:3] != 7'd0 |-> m_axis_tdata[2:0] == 3'd0)
        else $error("name with failure status");

    // message only given with success
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[41:10] == 32'd0)
        else $error("message with failure status");

endmodule

bind port_table_mailbox_manager_unit ptmm_port_checks u_ptmm_port_checks (.*);
